// ===== rtl/core/sphf_pkg.sv =====
// Shared types, constants and byte helpers of the sample packet header framer.
package sphf_pkg;

   // Register indexes of the configuration port.
   localparam logic [7:0] CSR_SYNC_WORD   = 8'd0;
   localparam logic [7:0] CSR_SAMPLE_TYPE = 8'd1;

   // Depth of the queue between the front and the back, and its counter width.
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Largest time magnitude and duration that the header can carry.
   localparam logic [55:0] MAX56 = {56{1'b1}};

   // Packed widths of the input item.
   localparam int REQ_DATA_W = 160;
   localparam int REQ_USER_W = 2;

   // One classified item, as it waits in the queue.
   typedef struct packed {
      logic [7:0]  sid;
      logic        sync;
      logic        neg;
      logic [2:0]  nts;
      logic [2:0]  ndur;
      logic [2:0]  nlen_m1;
      logic [32:0] len;
      logic [55:0] mag;
      logic [55:0] dur;
   } entry_type;

   // Number of bytes that v needs, but at least lo.
   function automatic logic [3:0] byte_len(input logic [63:0] v, input logic [3:0] lo);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (v[i*8 +: 8] != 8'd0) begin
            n = 4'(i + 1);
         end
      end
      if (n < lo) begin
         n = lo;
      end
      return n;
   endfunction

   // Byte i of v, counted from the least significant end.
   function automatic logic [7:0] byte_of(input logic [63:0] v, input logic [2:0] i);
      logic [63:0] s;
      s = v >> {i, 3'b000};
      return s[7:0];
   endfunction

endpackage

// ===== rtl/core/sphf_front.sv =====
// Front part: accepts sample items, works out magnitudes, counts and the length field.
module sphf_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sphf_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [sphf_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            req_tlast,
   input  logic                            pop,
   output logic                            push,
   output sphf_pkg::entry_type             push_entry
);
   import sphf_pkg::*;

   typedef struct packed {
      logic [7:0]  sid;
      logic        sync;
      logic        neg;
      logic [55:0] mag;
      logic [55:0] dur;
      logic [31:0] plen;
   } s1_type;

   logic [QCNT_W-1:0] reserved_ff, reserved_in;
   logic              s1_valid_ff, s1_valid_in;
   s1_type            s1_ff, s1_in;

   logic              take;
   logic [56:0]       start_t, stop_t, mag57;
   logic [57:0]       diff58;
   logic [3:0]        nts4, ndur4, nlen4;
   logic [2:0]        nts, ndur;
   logic [32:0]       len;

   // An item is taken only while the queue has room reserved for it.
   assign req_tready = (reserved_ff < QCNT_W'(QUEUE_DEPTH));
   assign take       = req_tvalid && req_tready && !req_tlast;

   // Places held by items in the first stage or in the queue.
   always_comb begin
      reserved_in = reserved_ff;
      if (take && !pop) begin
         reserved_in = reserved_ff + QCNT_W'(1);
      end else if (!take && pop) begin
         reserved_in = reserved_ff - QCNT_W'(1);
      end
   end

   // First stage: timestamp magnitude and clamped duration.
   always_comb begin
      start_t = req_tdata[64:8];
      stop_t  = req_tdata[121:65];
      mag57   = start_t[56] ? (57'd0 - start_t) : start_t;
      diff58  = {stop_t[56], stop_t} - {start_t[56], start_t};

      s1_in.sid  = req_tdata[7:0];
      s1_in.sync = req_tuser[0];
      s1_in.plen = req_tdata[153:122];
      if (req_tuser[1]) begin
         s1_in.neg = start_t[56];
         s1_in.mag = mag57[56] ? MAX56 : mag57[55:0];
         if (diff58[57]) begin
            s1_in.dur = 56'd0;
         end else if (diff58[56]) begin
            s1_in.dur = MAX56;
         end else begin
            s1_in.dur = diff58[55:0];
         end
      end else begin
         s1_in.neg = 1'b1;
         s1_in.mag = 56'd0;
         s1_in.dur = 56'd0;
      end
      s1_valid_in = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         reserved_ff <= reserved_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (take) begin
         s1_ff <= s1_in;
      end
   end

   // Second stage: byte counts and length field, written straight into the queue.
   always_comb begin
      nts4  = byte_len({8'd0, s1_ff.mag}, 4'd0);
      ndur4 = byte_len({8'd0, s1_ff.dur}, 4'd0);
      nts   = nts4[2:0];
      ndur  = ndur4[2:0];
      len   = {1'b0, s1_ff.plen} + 33'(nts) + 33'(ndur) + 33'd2;
      nlen4 = byte_len({31'd0, len}, 4'd1);

      push_entry.sid     = s1_ff.sid;
      push_entry.sync    = s1_ff.sync;
      push_entry.neg     = s1_ff.neg;
      push_entry.nts     = nts;
      push_entry.ndur    = ndur;
      push_entry.nlen_m1 = 3'(nlen4 - 4'd1);
      push_entry.len     = len;
      push_entry.mag     = s1_ff.mag;
      push_entry.dur     = s1_ff.dur;
   end

   assign push = s1_valid_ff;

endmodule

// ===== rtl/core/sphf_queue.sv =====
// Short queue of classified items between the front and the back.
module sphf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sphf_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                head_valid,
   output sphf_pkg::entry_type head_entry
);
   import sphf_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Pointers wrap at the queue depth; the front never pushes into a full queue.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

endmodule

// ===== rtl/core/sphf_back.sv =====
// Back part: sends the header of the queue head one byte per cycle unless stalled.
module sphf_back #(
   parameter int SYNC_BYTES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         sync_word,
   input  logic [4:0]          sample_type,
   input  logic                head_valid,
   input  sphf_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);
   import sphf_pkg::*;

   localparam logic [2:0] SYNC_LAST = 3'(SYNC_BYTES - 1);

   typedef enum logic [2:0] {
      ST_SYNC,
      ST_TYPE,
      ST_LEN,
      ST_SID,
      ST_FLAGS,
      ST_TS,
      ST_DUR
   } state_type;

   state_type  state_ff, state_in, st_nxt;
   logic [2:0] cnt_ff, cnt_in, cnt_nxt;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in, byte_sel;
   logic       rsp_last_ff, rsp_last_in;
   logic       emit, done;

   // A byte goes out when the head is there and the output register is free.
   assign emit = head_valid && (!rsp_valid_ff || rsp_tready);
   assign pop  = emit && done;

   // Field sequencer: byte of the current field and the step after it.
   always_comb begin
      byte_sel = 8'd0;
      st_nxt   = state_ff;
      cnt_nxt  = cnt_ff;
      done     = 1'b0;
      unique case (state_ff)
         ST_SYNC: begin
            byte_sel = byte_of({32'd0, sync_word}, cnt_ff);
            if (cnt_ff == 3'd0) begin
               st_nxt = ST_TYPE;
            end else begin
               cnt_nxt = cnt_ff - 3'd1;
            end
         end
         ST_TYPE: begin
            byte_sel = {sample_type, head_entry.nlen_m1};
            st_nxt   = ST_LEN;
            cnt_nxt  = head_entry.nlen_m1;
         end
         ST_LEN: begin
            byte_sel = byte_of({31'd0, head_entry.len}, cnt_ff);
            if (cnt_ff == 3'd0) begin
               st_nxt = ST_SID;
            end else begin
               cnt_nxt = cnt_ff - 3'd1;
            end
         end
         ST_SID: begin
            byte_sel = head_entry.sid;
            st_nxt   = ST_FLAGS;
         end
         ST_FLAGS: begin
            byte_sel = {head_entry.sync, head_entry.neg, head_entry.nts, head_entry.ndur};
            if (head_entry.nts != 3'd0) begin
               st_nxt  = ST_TS;
               cnt_nxt = head_entry.nts - 3'd1;
            end else if (head_entry.ndur != 3'd0) begin
               st_nxt  = ST_DUR;
               cnt_nxt = head_entry.ndur - 3'd1;
            end else begin
               done = 1'b1;
            end
         end
         ST_TS: begin
            byte_sel = byte_of({8'd0, head_entry.mag}, cnt_ff);
            if (cnt_ff != 3'd0) begin
               cnt_nxt = cnt_ff - 3'd1;
            end else if (head_entry.ndur != 3'd0) begin
               st_nxt  = ST_DUR;
               cnt_nxt = head_entry.ndur - 3'd1;
            end else begin
               done = 1'b1;
            end
         end
         ST_DUR: begin
            byte_sel = byte_of({8'd0, head_entry.dur}, cnt_ff);
            if (cnt_ff != 3'd0) begin
               cnt_nxt = cnt_ff - 3'd1;
            end else begin
               done = 1'b1;
            end
         end
         default: begin
            st_nxt  = ST_SYNC;
            cnt_nxt = SYNC_LAST;
         end
      endcase
      if (done) begin
         st_nxt  = ST_SYNC;
         cnt_nxt = SYNC_LAST;
      end
   end

   // Next values of the sequencer and the output register.
   always_comb begin
      state_in     = emit ? st_nxt : state_ff;
      cnt_in       = emit ? cnt_nxt : cnt_ff;
      rsp_data_in  = emit ? byte_sel : rsp_data_ff;
      rsp_last_in  = emit ? done : rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SYNC;
         cnt_ff       <= SYNC_LAST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/sample_packet_header_framer.sv =====
// Latency: with the back idle, an item passes the first-stage register and the queue before
// its first byte enters the output register. Throughput: one byte per cycle unless stalled;
// an item gives SYNC_BYTES + 3 + length bytes + time bytes, 8 to 26 with four sync bytes;
// the first stage and the queue hold four items, so the front takes items back to back
// until it fills. End-of-stream items take no place and give no bytes.
// Reset (synchronous, active high) empties the pipeline and queue and clears both registers.
module sample_packet_header_framer #(
   parameter int SYNC_BYTES = 4
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: stream_id[7:0], start_time[64:8], stop_time[121:65],
   // payload_length[153:122], zero fill[159:154]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,
   // req_tuser: is_sync[0], time_valid[1]
   input  logic [1:0]   req_tuser,
   // req_tlast: end_of_stream
   input  logic         req_tlast,
   // rsp_tdata: header_byte[7:0]; rsp_tlast: last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import sphf_pkg::*;

   logic [31:0] sync_word_ff, sync_word_in;
   logic [4:0]  sample_type_ff, sample_type_in;
   logic        push, pop, head_valid;
   entry_type   push_entry, head_entry;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      sync_word_in   = sync_word_ff;
      sample_type_in = sample_type_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC_WORD:   sync_word_in   = csr_data;
            CSR_SAMPLE_TYPE: sample_type_in = csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff   <= '0;
         sample_type_ff <= '0;
      end else begin
         sync_word_ff   <= sync_word_in;
         sample_type_ff <= sample_type_in;
      end
   end

   sphf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .pop        (pop),
      .push       (push),
      .push_entry (push_entry)
   );

   sphf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sphf_back #(
      .SYNC_BYTES (SYNC_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .sync_word   (sync_word_ff),
      .sample_type (sample_type_ff),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== rtl/core/sphf_checker.sv =====
// Port-level checks of the sample packet header framer and their binding to it.
module sphf_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic req_tlast,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast
);

   logic [3:0] outstanding_ff, outstanding_in;
   logic       req_take, rsp_done;

   // Headers started but not finished, counted at the ports.
   assign req_take = req_tvalid && req_tready && !req_tlast;
   assign rsp_done = rsp_tvalid && rsp_tready && rsp_tlast;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_done) begin
         outstanding_in = outstanding_ff + 4'd1;
      end else if (!req_take && rsp_done) begin
         outstanding_in = outstanding_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // Reset leaves no byte on the output.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // A stalled output stays valid and its end mark stays put.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tlast))
      else $error("stalled output item changed");

   // No byte appears without a header item in flight.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> outstanding_ff != 4'd0)
      else $error("header byte with no item in flight");

   // Back-pressure on the input only while items are in flight.
   a_ready_reason: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> outstanding_ff != 4'd0)
      else $error("input stalled with nothing in flight");

endmodule

bind sample_packet_header_framer sphf_checker u_sphf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);
